// ----- rtl/rmq_pkg.sv -----
// Package for the rotation-matrix-to-quaternion pipeline.
// Holds beat payload types, stage record types and fixed widths.
// No dependencies.
`default_nettype none

package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int DW        = 16;
  localparam int RADS_W    = DW + 2;
  localparam int RAD_W     = DW + 1;
  localparam int SQ_STEPS  = 17;
  localparam int SQ_IN_W   = 2 * SQ_STEPS;
  localparam int ROOT_W    = SQ_STEPS;
  localparam int REM_W     = ROOT_W + 3;
  localparam int NUM_W     = DW + 1;
  localparam int Q_W       = DW - 1;
  localparam int DIV_W     = ROOT_W + Q_W;
  localparam int ONE_VAL   = 1 << FRAC_BITS;

  localparam logic [1:0] SLOT_X = 2'd0;
  localparam logic [1:0] SLOT_Y = 2'd1;
  localparam logic [1:0] SLOT_Z = 2'd2;
  localparam logic [1:0] SLOT_W = 2'd3;

  typedef struct packed {
    logic signed [DW-1:0] e00;
    logic signed [DW-1:0] e01;
    logic signed [DW-1:0] e02;
    logic signed [DW-1:0] e10;
    logic signed [DW-1:0] e11;
    logic signed [DW-1:0] e12;
    logic signed [DW-1:0] e20;
    logic signed [DW-1:0] e21;
    logic signed [DW-1:0] e22;
    logic signed [DW-1:0] e33;
  } rmq_in_t;

  typedef struct packed {
    logic signed [DW-1:0] qx;
    logic signed [DW-1:0] qy;
    logic signed [DW-1:0] qz;
    logic signed [DW-1:0] qw;
    logic                 bad_input;
  } rmq_out_t;

  typedef struct packed {
    logic [3:0][NUM_W-1:0] num;
    logic [1:0]            slot;
    logic                  bad;
  } rmq_tag_t;

  typedef struct packed {
    logic [SQ_IN_W-1:0] n;
    logic [REM_W-1:0]   rem;
    logic [ROOT_W-1:0]  root;
  } rmq_sq_t;

  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [Q_W-1:0]    nlo;
    logic [Q_W-1:0]    q;
  } rmq_dl_t;

  typedef struct packed {
    logic [ROOT_W-1:0] d;
    logic [DW-1:0]     q4;
    logic [3:0]        neg;
    logic [3:0]        ovf;
    logic [1:0]        slot;
    logic              bad;
  } rmq_dc_t;

endpackage

`default_nettype wire

// ----- rtl/rotation_matrix_to_quaternion.sv -----
// Pipelined rotation matrix to unit quaternion converter (Shepperd's method).
// Depends on rmq_pkg for payload types, stage records and widths.
//
//   channel | ports                       | handshake
//   input   | start, busy, in_data        | beat taken when start && !busy
//   result  | out_strobe, out_data        | one-cycle strobe, no back-pressure
//
// A new beat may enter on every clock; busy stays low.
// Each result passes through 2 setup stages, 17 square root stages, 2 divider
// setup stages, 15 restoring divider stages and the output register. Synchronous
// active-low reset clears all valid bits; data is not reset.
`default_nettype none

module rotation_matrix_to_quaternion (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rmq_pkg::rmq_in_t  in_data,
  output logic              out_strobe,
  output rmq_pkg::rmq_out_t out_data
);
  import rmq_pkg::*;

  localparam int V_D0 = 2 + SQ_STEPS;
  localparam int V_D1 = V_D0 + 1;
  localparam int LAT  = V_D1 + Q_W + 2;

  function automatic rmq_sq_t sq_step(rmq_sq_t a);
    rmq_sq_t          b;
    logic [REM_W-1:0] r;
    logic [REM_W-1:0] t;
    r   = {a.rem[REM_W-3:0], a.n[SQ_IN_W-1 -: 2]};
    t   = REM_W'({a.root, 2'b01});
    b.n = {a.n[SQ_IN_W-3:0], 2'b00};
    if (r >= t) begin
      b.rem  = r - t;
      b.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      b.rem  = r;
      b.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return b;
  endfunction

  function automatic rmq_dl_t dv_step(rmq_dl_t a, logic [ROOT_W-1:0] d);
    rmq_dl_t         b;
    logic [ROOT_W:0] r;
    r     = {a.rem, a.nlo[Q_W-1]};
    b.nlo = {a.nlo[Q_W-2:0], 1'b0};
    if (r >= {1'b0, d}) begin
      b.rem = ROOT_W'(r - {1'b0, d});
      b.q   = {a.q[Q_W-2:0], 1'b1};
    end else begin
      b.rem = ROOT_W'(r);
      b.q   = {a.q[Q_W-2:0], 1'b0};
    end
    return b;
  endfunction

  function automatic logic [DW-1:0] sat_lane(logic neg, logic ovf, logic [Q_W-1:0] q);
    logic [DW-1:0] v;
    if (ovf) begin
      v = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else if (neg) begin
      v = -{1'b0, q};
    end else begin
      v = {1'b0, q};
    end
    return v;
  endfunction

  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] vld_nxt;

  rmq_in_t              in_r;
  logic signed [DW-1:0] m [3][3];
  logic signed [RADS_W-1:0] trace;
  logic signed [RADS_W-1:0] rad_maj;
  logic signed [RADS_W-1:0] rad;
  logic                 tr_ok;
  logic [1:0]           ax;
  logic [1:0]           aj;
  logic [1:0]           ak;
  logic signed [NUM_W-1:0] nm [4];
  rmq_tag_t             tag_nxt;

  logic [RAD_W-1:0] s2_rad_r;
  rmq_tag_t         s2_tag_r;

  rmq_sq_t  sq_init;
  rmq_sq_t  sq_r  [SQ_STEPS];
  rmq_tag_t sqt_r [SQ_STEPS];

  logic [ROOT_W-1:0] root;
  logic [ROOT_W:0]   root_p2;
  logic [NUM_W-1:0]  mag [4];
  logic [3:0]        neg;

  logic [ROOT_W-1:0] d0_d_r;
  logic [DW-1:0]     d0_q4_r;
  logic [DIV_W-1:0]  d0_n_r [4];
  logic [3:0]        d0_neg_r;
  rmq_tag_t          d0_tag_r;

  rmq_dl_t d1_dl_r [4];
  rmq_dc_t d1_dc_r;

  rmq_dl_t dl_r [Q_W][4];
  rmq_dc_t dc_r [Q_W];

  rmq_out_t out_r;
  rmq_out_t out_nxt;
  logic [3:0][DW-1:0] lane_v;

  assign busy    = 1'b0;
  assign vld_nxt = {vld_r[LAT-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_data;
    end
  end

  assign m[0][0] = in_r.e00;
  assign m[0][1] = in_r.e01;
  assign m[0][2] = in_r.e02;
  assign m[1][0] = in_r.e10;
  assign m[1][1] = in_r.e11;
  assign m[1][2] = in_r.e12;
  assign m[2][0] = in_r.e20;
  assign m[2][1] = in_r.e21;
  assign m[2][2] = in_r.e22;

  always_comb begin
    trace = RADS_W'(m[0][0]) + RADS_W'(m[1][1]) + RADS_W'(m[2][2]) + RADS_W'(in_r.e33);
    tr_ok = trace >= $signed(RADS_W'(ONE_VAL));
    ax    = (m[0][0] > m[1][1]) ? SLOT_X : SLOT_Y;
    if (m[2][2] > m[ax][ax]) begin
      ax = SLOT_Z;
    end
    unique case (ax)
      SLOT_X: begin
        aj = SLOT_Y;
        ak = SLOT_Z;
      end
      SLOT_Y: begin
        aj = SLOT_Z;
        ak = SLOT_X;
      end
      default: begin
        aj = SLOT_X;
        ak = SLOT_Y;
      end
    endcase
    rad_maj = RADS_W'(m[ax][ax]) - RADS_W'(m[aj][aj]) - RADS_W'(m[ak][ak])
            + RADS_W'(in_r.e33);
    for (int l = 0; l < 4; l++) begin
      nm[l] = '0;
    end
    if (tr_ok) begin
      nm[SLOT_X]   = NUM_W'(m[1][2]) - NUM_W'(m[2][1]);
      nm[SLOT_Y]   = NUM_W'(m[2][0]) - NUM_W'(m[0][2]);
      nm[SLOT_Z]   = NUM_W'(m[0][1]) - NUM_W'(m[1][0]);
      rad          = trace;
      tag_nxt.slot = SLOT_W;
      tag_nxt.bad  = 1'b0;
    end else begin
      nm[aj]       = NUM_W'(m[aj][ax]) + NUM_W'(m[ax][aj]);
      nm[ak]       = NUM_W'(m[ak][ax]) + NUM_W'(m[ax][ak]);
      nm[SLOT_W]   = NUM_W'(m[aj][ak]) - NUM_W'(m[ak][aj]);
      rad          = rad_maj;
      tag_nxt.slot = ax;
      tag_nxt.bad  = rad_maj <= 0;
    end
    for (int l = 0; l < 4; l++) begin
      tag_nxt.num[l] = nm[l];
    end
  end

  always_ff @(posedge clk) begin
    s2_rad_r <= rad[RAD_W-1:0];
    s2_tag_r <= tag_nxt;
  end

  always_comb begin
    sq_init.n    = SQ_IN_W'(s2_rad_r) << (FRAC_BITS + 2);
    sq_init.rem  = '0;
    sq_init.root = '0;
  end

  always_ff @(posedge clk) begin
    sq_r[0]  <= sq_step(sq_init);
    sqt_r[0] <= s2_tag_r;
    for (int t = 1; t < SQ_STEPS; t++) begin
      sq_r[t]  <= sq_step(sq_r[t-1]);
      sqt_r[t] <= sqt_r[t-1];
    end
  end

  always_comb begin
    root    = sq_r[SQ_STEPS-1].root;
    root_p2 = {1'b0, root} + (ROOT_W+1)'(2);
    for (int l = 0; l < 4; l++) begin
      neg[l] = sqt_r[SQ_STEPS-1].num[l][NUM_W-1];
      mag[l] = neg[l] ? -sqt_r[SQ_STEPS-1].num[l] : sqt_r[SQ_STEPS-1].num[l];
    end
  end

  always_ff @(posedge clk) begin
    d0_d_r   <= root;
    d0_q4_r  <= DW'(root_p2 >> 2);
    d0_neg_r <= neg;
    d0_tag_r <= sqt_r[SQ_STEPS-1];
    for (int l = 0; l < 4; l++) begin
      d0_n_r[l] <= (DIV_W'(mag[l]) << FRAC_BITS) + DIV_W'(root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    d1_dc_r.d    <= d0_d_r;
    d1_dc_r.q4   <= d0_q4_r;
    d1_dc_r.neg  <= d0_neg_r;
    d1_dc_r.slot <= d0_tag_r.slot;
    d1_dc_r.bad  <= d0_tag_r.bad;
    for (int l = 0; l < 4; l++) begin
      d1_dc_r.ovf[l] <= d0_n_r[l] >= (DIV_W'(d0_d_r) << Q_W);
      d1_dl_r[l].rem <= d0_n_r[l][DIV_W-1:Q_W];
      d1_dl_r[l].nlo <= d0_n_r[l][Q_W-1:0];
      d1_dl_r[l].q   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    dc_r[0] <= d1_dc_r;
    for (int l = 0; l < 4; l++) begin
      dl_r[0][l] <= dv_step(d1_dl_r[l], d1_dc_r.d);
    end
    for (int t = 1; t < Q_W; t++) begin
      dc_r[t] <= dc_r[t-1];
      for (int l = 0; l < 4; l++) begin
        dl_r[t][l] <= dv_step(dl_r[t-1][l], dc_r[t-1].d);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      lane_v[l] = sat_lane(dc_r[Q_W-1].neg[l], dc_r[Q_W-1].ovf[l], dl_r[Q_W-1][l].q);
    end
    lane_v[dc_r[Q_W-1].slot] = dc_r[Q_W-1].q4;
    if (dc_r[Q_W-1].bad) begin
      out_nxt = '0;
      out_nxt.bad_input = 1'b1;
    end else begin
      out_nxt.qx        = lane_v[SLOT_X];
      out_nxt.qy        = lane_v[SLOT_Y];
      out_nxt.qz        = lane_v[SLOT_Z];
      out_nxt.qw        = lane_v[SLOT_W];
      out_nxt.bad_input = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_r[LAT-2]) begin
      out_r <= out_nxt;
    end
  end

  assign out_strobe = vld_r[LAT-1];
  assign out_data   = out_r;

  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, LAT))
    else $error("result beat without a matching input beat");

  a_bad_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.bad_input |->
      out_data.qx == 0 && out_data.qy == 0 && out_data.qz == 0 && out_data.qw == 0)
    else $error("flagged result carries nonzero components");

  a_root_min : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[V_D0] && !d0_tag_r.bad |-> d0_d_r >= ROOT_W'(2))
    else $error("square root below two for a positive radicand");

  a_trace_ok : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[V_D1] && d1_dc_r.slot == SLOT_W |-> !d1_dc_r.bad)
    else $error("trace branch flagged as bad input");

endmodule

`default_nettype wire
